// ----- design/stkm_pkg.sv -----
// Shared types and codes for the stack machine microstep datapath.
package stkm_pkg;

	typedef enum logic [1:0] {
		CMD_EXEC     = 2'd0,
		CMD_LOAD_MEM = 2'd1,
		CMD_LOAD_REG = 2'd2,
		CMD_READ_MEM = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ALU_AND  = 2'd0,
		ALU_OR   = 2'd1,
		ALU_NOTB = 2'd2,
		ALU_ADD  = 2'd3
	} alu_fn_t;

	typedef enum logic [3:0] {
		RC_MAR = 4'd0,
		RC_MDR = 4'd1,
		RC_PC  = 4'd2,
		RC_MBR = 4'd3,
		RC_SP  = 4'd4,
		RC_LV  = 4'd5,
		RC_CPP = 4'd6,
		RC_TOS = 4'd7,
		RC_OPC = 4'd8,
		RC_H   = 4'd9
	} reg_choice_t;

	localparam logic [3:0] B_MDR   = 4'd0;
	localparam logic [3:0] B_PC    = 4'd1;
	localparam logic [3:0] B_MBRS  = 4'd2;
	localparam logic [3:0] B_MBRU  = 4'd3;
	localparam logic [3:0] B_SP    = 4'd4;
	localparam logic [3:0] B_LV    = 4'd5;
	localparam logic [3:0] B_CPP   = 4'd6;
	localparam logic [3:0] B_TOS   = 4'd7;

	localparam int MW_SLL8  = 22;
	localparam int MW_SRA1  = 21;
	localparam int MW_F0    = 20;
	localparam int MW_F1    = 19;
	localparam int MW_ENA   = 18;
	localparam int MW_ENB   = 17;
	localparam int MW_INVA  = 16;
	localparam int MW_INC   = 15;
	localparam int MW_C_H   = 14;
	localparam int MW_C_OPC = 13;
	localparam int MW_C_TOS = 12;
	localparam int MW_C_CPP = 11;
	localparam int MW_C_LV  = 10;
	localparam int MW_C_SP  = 9;
	localparam int MW_C_PC  = 8;
	localparam int MW_C_MDR = 7;
	localparam int MW_C_MAR = 6;
	localparam int MW_WRITE = 5;
	localparam int MW_READ  = 4;

	localparam int UWORD_W = 23;
	localparam int WORDS_W = 9;

	typedef struct packed {
		logic [31:0] h;
		logic [31:0] opc;
		logic [31:0] tos;
		logic [31:0] cpp;
		logic [31:0] lv;
		logic [31:0] sp;
		logic [31:0] pc;
		logic [31:0] mdr;
		logic [31:0] mar;
		logic [7:0]  mbr;
	} arch_regs_t;

	typedef struct packed {
		logic        we;
		logic        re;
		logic [31:0] addr;
		logic [31:0] wdata;
	} mem_req_t;

endpackage

// ----- design/stkm_alu.sv -----
// B-bus select, ALU and shifter of the microstep datapath.
module stkm_alu (
	input  logic [stkm_pkg::UWORD_W-1:0] uword,
	input  stkm_pkg::arch_regs_t         regs,
	output logic [31:0]                  result
);

	logic [31:0] b_sel;
	logic [31:0] a_op;
	logic [31:0] b_op;
	logic [31:0] alu_out;
	logic [31:0] shl_out;

	always_comb begin
		case (uword[3:0])
			stkm_pkg::B_MDR:  b_sel = regs.mdr;
			stkm_pkg::B_PC:   b_sel = regs.pc;
			stkm_pkg::B_MBRS: b_sel = {{24{regs.mbr[7]}}, regs.mbr};
			stkm_pkg::B_MBRU: b_sel = {24'd0, regs.mbr};
			stkm_pkg::B_SP:   b_sel = regs.sp;
			stkm_pkg::B_LV:   b_sel = regs.lv;
			stkm_pkg::B_CPP:  b_sel = regs.cpp;
			stkm_pkg::B_TOS:  b_sel = regs.tos;
			default:          b_sel = regs.opc;
		endcase

		a_op = uword[stkm_pkg::MW_ENA] ?
			(uword[stkm_pkg::MW_INVA] ? ~regs.h : regs.h) : 32'd0;
		b_op = uword[stkm_pkg::MW_ENB] ? b_sel : 32'd0;

		case (stkm_pkg::alu_fn_t'({uword[stkm_pkg::MW_F0], uword[stkm_pkg::MW_F1]}))
			stkm_pkg::ALU_AND:  alu_out = a_op & b_op;
			stkm_pkg::ALU_OR:   alu_out = a_op | b_op;
			stkm_pkg::ALU_NOTB: alu_out = ~b_op;
			default:            alu_out = a_op + b_op + {31'd0, uword[stkm_pkg::MW_INC]};
		endcase

		shl_out = uword[stkm_pkg::MW_SLL8] ? {alu_out[23:0], 8'd0} : alu_out;
		result  = uword[stkm_pkg::MW_SRA1] ? {shl_out[31], shl_out[31:1]} : shl_out;
	end

endmodule

// ----- design/stkm_mem.sv -----
// Data memory with one write port and one registered read port.
module stkm_mem #(
	parameter int MEM_DEPTH = 256
) (
	input  logic               clk,
	input  stkm_pkg::mem_req_t req,
	output logic [31:0]        rd_data
);

	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic [31:0] mem [MEM_DEPTH];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem[req.addr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/stack_machine_microstep_datapath.sv -----
// Stack machine microstep datapath top level: input stage, register file, result stage.
// Path: input register, then the register file. Throughput: one word per cycle unless
// m_axis_tready stalls the output; each step runs B select, ALU, shifter and address
// check between the input register and the register file / memory read register.
// Reset clears the register file, pending/status flags, word-count and both valid flags.
// Memory contents are undefined after reset until written; there is no clearing pass.
module stack_machine_microstep_datapath #(
	parameter int MEM_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// micro_word[22:0], target_address[30:23], load_value[62:31], register_choice[66:63]
	input  logic [71:0]  s_axis_tdata,
	// cmd[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// h[31:0], opc[63:32], tos[95:64], cpp[127:96], lv[159:128], sp[191:160],
	// pc[223:192], mdr[255:224], mar[287:256], mbr[295:288], access_status[296],
	// read_back_data[328:297]
	output logic [335:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [stkm_pkg::WORDS_W-1:0] cfg_wdata
);

	logic                                valid_s1;
	stkm_pkg::cmd_t                      cmd_s1;
	logic [stkm_pkg::UWORD_W-1:0]        uword_s1;
	logic [7:0]                          taddr_s1;
	logic [31:0]                         lval_s1;
	logic [3:0]                          rchoice_s1;

	stkm_pkg::arch_regs_t                regs_q;
	logic                                mdr_pend_q;
	logic                                rb_pend_q;
	logic                                status_q;
	logic                                out_valid_q;
	logic [stkm_pkg::WORDS_W-1:0]        words_used_q;

	stkm_pkg::arch_regs_t                cur;
	stkm_pkg::arch_regs_t                nxt;
	stkm_pkg::mem_req_t                  req;
	stkm_pkg::mem_req_t                  mem_req;
	logic [31:0]                         alu_result;
	logic [31:0]                         rd_data;
	logic [31:0]                         limit;
	logic [31:0]                         read_back;
	logic                                status_d;
	logic                                mdr_pend_d;
	logic                                rb_pend_d;
	logic                                exec_fire;
	logic                                s_accept;

	assign exec_fire     = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || exec_fire;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (exec_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1     <= stkm_pkg::cmd_t'(s_axis_tuser);
			uword_s1   <= s_axis_tdata[22:0];
			taddr_s1   <= s_axis_tdata[30:23];
			lval_s1    <= s_axis_tdata[62:31];
			rchoice_s1 <= s_axis_tdata[66:63];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_used_q <= '0;
		end else if (cfg_we) begin
			words_used_q <= cfg_wdata;
		end
	end

	assign limit = (32'(words_used_q) > 32'(MEM_DEPTH)) ? 32'(MEM_DEPTH) : 32'(words_used_q);

	always_comb begin
		cur     = regs_q;
		cur.mdr = mdr_pend_q ? rd_data : regs_q.mdr;
	end

	stkm_alu u_alu (
		.uword  (uword_s1),
		.regs   (cur),
		.result (alu_result)
	);

	always_comb begin
		nxt        = cur;
		req        = '0;
		status_d   = 1'b0;
		mdr_pend_d = 1'b0;
		rb_pend_d  = 1'b0;
		case (cmd_s1)
			stkm_pkg::CMD_EXEC: begin
				if (uword_s1[stkm_pkg::MW_READ] && uword_s1[stkm_pkg::MW_WRITE]) begin
					nxt.mbr = uword_s1[22:15];
					nxt.h   = {24'd0, uword_s1[22:15]};
				end else begin
					if (uword_s1[stkm_pkg::MW_C_H])   nxt.h   = alu_result;
					if (uword_s1[stkm_pkg::MW_C_OPC]) nxt.opc = alu_result;
					if (uword_s1[stkm_pkg::MW_C_TOS]) nxt.tos = alu_result;
					if (uword_s1[stkm_pkg::MW_C_CPP]) nxt.cpp = alu_result;
					if (uword_s1[stkm_pkg::MW_C_LV])  nxt.lv  = alu_result;
					if (uword_s1[stkm_pkg::MW_C_SP])  nxt.sp  = alu_result;
					if (uword_s1[stkm_pkg::MW_C_PC])  nxt.pc  = alu_result;
					if (uword_s1[stkm_pkg::MW_C_MDR]) nxt.mdr = alu_result;
					if (uword_s1[stkm_pkg::MW_C_MAR]) nxt.mar = alu_result;
					if (uword_s1[stkm_pkg::MW_READ] || uword_s1[stkm_pkg::MW_WRITE]) begin
						if (nxt.mar < limit) begin
							req.addr   = nxt.mar;
							req.wdata  = nxt.mdr;
							req.we     = uword_s1[stkm_pkg::MW_WRITE];
							req.re     = uword_s1[stkm_pkg::MW_READ];
							mdr_pend_d = uword_s1[stkm_pkg::MW_READ];
						end else begin
							status_d = 1'b1;
						end
					end
				end
			end
			stkm_pkg::CMD_LOAD_MEM: begin
				if ({24'd0, taddr_s1} < limit) begin
					req.addr  = {24'd0, taddr_s1};
					req.wdata = lval_s1;
					req.we    = 1'b1;
				end else begin
					status_d = 1'b1;
				end
			end
			stkm_pkg::CMD_LOAD_REG: begin
				case (stkm_pkg::reg_choice_t'(rchoice_s1))
					stkm_pkg::RC_MAR: nxt.mar = lval_s1;
					stkm_pkg::RC_MDR: nxt.mdr = lval_s1;
					stkm_pkg::RC_PC:  nxt.pc  = lval_s1;
					stkm_pkg::RC_MBR: nxt.mbr = lval_s1[7:0];
					stkm_pkg::RC_SP:  nxt.sp  = lval_s1;
					stkm_pkg::RC_LV:  nxt.lv  = lval_s1;
					stkm_pkg::RC_CPP: nxt.cpp = lval_s1;
					stkm_pkg::RC_TOS: nxt.tos = lval_s1;
					stkm_pkg::RC_OPC: nxt.opc = lval_s1;
					stkm_pkg::RC_H:   nxt.h   = lval_s1;
					default:          nxt     = cur;
				endcase
			end
			default: begin
				if ({24'd0, taddr_s1} < limit) begin
					req.addr  = {24'd0, taddr_s1};
					req.re    = 1'b1;
					rb_pend_d = 1'b1;
				end else begin
					status_d = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		mem_req    = req;
		mem_req.we = req.we && exec_fire;
		mem_req.re = req.re && exec_fire;
	end

	stkm_mem #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q      <= '0;
			mdr_pend_q  <= 1'b0;
			rb_pend_q   <= 1'b0;
			status_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_fire) begin
				regs_q      <= nxt;
				mdr_pend_q  <= mdr_pend_d;
				rb_pend_q   <= rb_pend_d;
				status_q    <= status_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign read_back     = rb_pend_q ? rd_data : 32'd0;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, read_back, status_q, regs_q.mbr, regs_q.mar, cur.mdr,
		regs_q.pc, regs_q.sp, regs_q.lv, regs_q.cpp, regs_q.tos, regs_q.opc, regs_q.h};

endmodule
